[sv/aps_pkg.sv]
package aps_pkg;

   // Field and storage sizes fixed by the item and register formats
   localparam int MAX_PATTERN     = 64;
   localparam int PAT_IDX_W       = 6;
   localparam int LEN_W           = 7;
   localparam int ALIGN_W         = 2;
   localparam int LANE_LO_W       = 3;
   localparam int ADDR_W          = 64;
   localparam int FUNC_W          = 2;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 7;
   localparam int DEF_BLOCK_BYTES = 16384;

   localparam logic [LEN_W-1:0]   RESET_PATTERN_LENGTH = 7'd1;
   localparam logic [ALIGN_W-1:0] RESET_ALIGN_SHIFT    = 2'd2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SCAN  = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_START = 2'd2
   } func_type;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_PATTERN_LENGTH = 1'b0;
   localparam csr_index_type CSR_ALIGN_SHIFT    = 1'b1;

   typedef logic [7:0] byte_type;
   typedef logic [MAX_PATTERN-1:0][7:0] pattern_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      byte_type             data_byte;
      logic [PAT_IDX_W-1:0] pattern_index;
      logic [ADDR_W-1:0]    region_base;
   } item_type;

   typedef struct packed {
      logic [LEN_W-1:0]   pattern_length;
      logic [ALIGN_W-1:0] align_shift;
   } cfg_type;

   // Pattern store control: byte writes from load transactions, full
   // realignment when the pattern length register is written
   typedef struct packed {
      logic                 wr_en;
      logic [PAT_IDX_W-1:0] wr_index;
      byte_type             wr_byte;
      logic                 realign_en;
      logic [LEN_W-1:0]     realign_len;
   } pat_ctl_type;

endpackage

[sv/aps_if.sv]
interface aps_req_if import aps_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [7:0]           data_byte;
   logic [PAT_IDX_W-1:0] pattern_index;
   logic [ADDR_W-1:0]    region_base;

   modport source (output valid, func, data_byte, pattern_index, region_base, input ready);
   modport sink   (input valid, func, data_byte, pattern_index, region_base, output ready);
endinterface

interface aps_rsp_if import aps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] match_address;

   modport source (output valid, match_address, input ready);
   modport sink   (input valid, match_address, output ready);
endinterface

interface aps_csr_if import aps_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/aps_pattern_store.sv]
// Raw pattern bytes plus a copy laid out so that lane j holds the
// pattern byte compared against the j-th most recent stream byte.
module aps_pattern_store import aps_pkg::*; (
   input  logic        clock,
   input  pat_ctl_type ctl,
   input  logic [LEN_W-1:0] pattern_length,
   output pattern_type aligned
);

   pattern_type raw_ff, raw_in;
   pattern_type aligned_ff, aligned_in;
   pattern_type reversed;
   pattern_type shifted;
   logic [PAT_IDX_W-1:0] shift_amt;
   logic [LEN_W-1:0]     wr_pos;

   always_comb begin
      raw_in = raw_ff;
      if (ctl.wr_en) begin
         raw_in[ctl.wr_index] = ctl.wr_byte;
      end
   end

   // aligned[j] = raw[len-1-j]: reverse, then shift down by 64-len bytes
   always_comb begin
      for (int m = 0; m < MAX_PATTERN; m++) begin
         reversed[m] = raw_ff[MAX_PATTERN-1-m];
      end
      shift_amt = PAT_IDX_W'(LEN_W'(MAX_PATTERN) - ctl.realign_len);
      shifted = reversed;
      for (int k = 0; k < PAT_IDX_W; k++) begin
         if (shift_amt[k]) begin
            shifted = shifted >> (8 << k);
         end
      end
   end

   always_comb begin
      aligned_in = aligned_ff;
      wr_pos = pattern_length - LEN_W'(1) - {1'b0, ctl.wr_index};
      priority if (ctl.realign_en) begin
         aligned_in = shifted;
      end else if (ctl.wr_en && ({1'b0, ctl.wr_index} < pattern_length)) begin
         aligned_in[wr_pos[PAT_IDX_W-1:0]] = ctl.wr_byte;
      end else begin
         aligned_in = aligned_ff;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff     <= raw_in;
      aligned_ff <= aligned_in;
   end

   assign aligned = aligned_ff;

endmodule

[sv/aps_scan_core.sv]
// Byte window, region/block position tracking and the parallel compare.
module aps_scan_core import aps_pkg::*; #(
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  item_type          item,
   input  cfg_type           cfg,
   input  pattern_type       pattern,
   output logic              hit,
   output logic [ADDR_W-1:0] match_address
);

   localparam int BO_W = $clog2(BLOCK_BYTES);
   localparam logic [BO_W-1:0] BO_LAST = BO_W'(BLOCK_BYTES - 1);
   localparam int WIN_DEPTH = MAX_PATTERN - 1;

   logic [WIN_DEPTH-1:0][7:0] window_ff, window_in;
   logic [ADDR_W-1:0]         cur_addr_ff, cur_addr_in;   // address of next byte
   logic [LANE_LO_W-1:0]      roff_lo_ff, roff_lo_in;     // low bits of region offset
   logic [BO_W-1:0]           block_off_ff, block_off_in;

   logic                   is_scan;
   logic                   is_start;
   logic [LEN_W-1:0]       lm1;
   logic                   len_ok;
   logic                   block_ok;
   logic [LANE_LO_W-1:0]   align_mask;
   logic [LANE_LO_W-1:0]   start_lo;
   logic                   align_ok;
   pattern_type            lanes;
   logic [MAX_PATTERN-1:0] lane_ok;

   always_comb begin
      is_scan  = fire && (item.func == FUNC_SCAN);
      is_start = fire && (item.func == FUNC_START);
      lm1      = cfg.pattern_length - LEN_W'(1);
      len_ok   = (cfg.pattern_length != '0) &&
                 (cfg.pattern_length <= LEN_W'(MAX_PATTERN));
      block_ok = 32'(block_off_ff) >= 32'(lm1);
      align_mask = ~(3'b111 << cfg.align_shift);
      start_lo   = roff_lo_ff - lm1[LANE_LO_W-1:0];
      align_ok   = (start_lo & align_mask) == '0;
      // lane 0 is the incoming byte, lane j the byte j positions back
      lanes = {window_ff, item.data_byte};
      for (int j = 0; j < MAX_PATTERN; j++) begin
         lane_ok[j] = (LEN_W'(j) >= cfg.pattern_length) || (pattern[j] == lanes[j]);
      end
      hit = is_scan && len_ok && block_ok && align_ok && (&lane_ok);
      match_address = cur_addr_ff - ADDR_W'(lm1);
   end

   always_comb begin
      window_in    = window_ff;
      cur_addr_in  = cur_addr_ff;
      roff_lo_in   = roff_lo_ff;
      block_off_in = block_off_ff;
      if (is_start) begin
         window_in    = '0;
         cur_addr_in  = item.region_base;
         roff_lo_in   = '0;
         block_off_in = '0;
      end else if (is_scan) begin
         window_in    = {window_ff[WIN_DEPTH-2:0], item.data_byte};
         cur_addr_in  = cur_addr_ff + ADDR_W'(1);
         roff_lo_in   = roff_lo_ff + LANE_LO_W'(1);
         block_off_in = (block_off_ff == BO_LAST) ? '0 : block_off_ff + BO_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         cur_addr_ff  <= '0;
         roff_lo_ff   <= '0;
         block_off_ff <= '0;
      end else begin
         window_ff    <= window_in;
         cur_addr_ff  <= cur_addr_in;
         roff_lo_ff   <= roff_lo_in;
         block_off_ff <= block_off_in;
      end
   end

endmodule

[sv/aligned_pattern_scanner_unit.sv]
// Aligned byte pattern scanner.
// req_if carries one transaction per command: FUNC_START opens a region at
// region_base, FUNC_LOAD writes data_byte to pattern position pattern_index,
// FUNC_SCAN feeds the next region byte in address order. A scan byte that
// completes a match of pattern_length bytes, starting on a 2**align_shift
// boundary and lying inside one BLOCK_BYTES block of the region, produces one
// rsp_if transaction carrying the match start address. csr_if writes the two
// registers (0: pattern_length, 1: align_shift) and is always ready.
// Timing: a transaction is held in the input stage and compared there; a match
// is registered in the output register driving rsp_if. One transaction per
// cycle is sustained while rsp_if takes results, via the 64-lane window compare.
// A stalled rsp_if holds the match in the output register; the input stage
// still accepts one more transaction, then req_if.ready drops until the
// result is taken.
// Reset clears the byte window, region position, base address and the
// handshake state, and sets pattern_length 1 and align_shift 2. Pattern
// bytes are not cleared and must be loaded before use.
module aligned_pattern_scanner_unit import aps_pkg::*; #(
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input logic       clock,
   input logic       reset,
   aps_req_if.sink   req_if,
   aps_rsp_if.source rsp_if,
   aps_csr_if.sink   csr_if
);

   // input stage
   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff, s1_item_in;

   // output stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   logic              req_fire;
   logic              advance;     // output register free this cycle
   logic              exec_fire;   // input stage item executes
   logic              csr_fire;
   logic              hit;
   logic [ADDR_W-1:0] match_address;
   pat_ctl_type       pat_ctl;
   pattern_type       aligned_pattern;

   assign advance   = !rsp_valid_ff || rsp_if.ready;
   assign exec_fire = s1_valid_ff && advance;
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_fire  = req_if.valid && req_if.ready;

   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_fire) begin
         s1_valid_in              = 1'b1;
         s1_item_in.func          = req_if.func;
         s1_item_in.data_byte     = req_if.data_byte;
         s1_item_in.pattern_index = req_if.pattern_index;
         s1_item_in.region_base   = req_if.region_base;
      end else if (exec_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // result register; loads and starts drop out here with no transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (advance) begin
         rsp_valid_in = exec_fire && hit;
         if (exec_fire && hit) begin
            rsp_addr_in = match_address;
         end
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         unique case (csr_if.index)
            CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr_if.data[LEN_W-1:0];
            CSR_ALIGN_SHIFT:    cfg_in.align_shift    = csr_if.data[ALIGN_W-1:0];
         endcase
      end
   end

   // loads write the store at execute; a length change rebuilds the lane layout
   always_comb begin
      pat_ctl.wr_en       = exec_fire && (s1_item_ff.func == FUNC_LOAD);
      pat_ctl.wr_index    = s1_item_ff.pattern_index;
      pat_ctl.wr_byte     = s1_item_ff.data_byte;
      pat_ctl.realign_en  = csr_fire && (csr_if.index == CSR_PATTERN_LENGTH);
      pat_ctl.realign_len = csr_if.data[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         cfg_ff.pattern_length <= RESET_PATTERN_LENGTH;
         cfg_ff.align_shift    <= RESET_ALIGN_SHIFT;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   aps_pattern_store u_pattern_store (
      .clock          (clock),
      .ctl            (pat_ctl),
      .pattern_length (cfg_ff.pattern_length),
      .aligned        (aligned_pattern)
   );

   aps_scan_core #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_scan_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (exec_fire),
      .item          (s1_item_ff),
      .cfg           (cfg_ff),
      .pattern       (aligned_pattern),
      .hit           (hit),
      .match_address (match_address)
   );

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.match_address = rsp_addr_ff;

endmodule
